// ----- src/rbsi_pkg.sv -----
// shared types and register codes for the ray/box slab intersection unit
// no dependencies; used by rbsi_fxmul and the top level (rbsi_slab_merge does not use it)
`default_nettype none

package rbsi_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } rbsi_reg_e;

  // load enables of the two register stages of a fixed-point multiplier
  typedef struct packed {
    logic load_prod;
    logic load_res;
  } rbsi_mul_en_t;

endpackage

`default_nettype wire

// ----- src/rbsi_fxmul.sv -----
// two-stage fixed-point multiplier: full product, then truncate toward zero and saturate
// depends on rbsi_pkg for the stage enable struct
`default_nettype none

module rbsi_fxmul #(
  parameter int unsigned A_WIDTH     = 33,
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  rbsi_pkg::rbsi_mul_en_t        en_i,
  input  logic signed [A_WIDTH-1:0]     a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  output logic signed [COORD_WIDTH-1:0] res_o
);

  localparam int unsigned PW = A_WIDTH + COORD_WIDTH;
  localparam int unsigned HW = PW - COORD_WIDTH + 1;

  logic signed [PW-1:0]          prod_d, prod_q;
  logic signed [PW-1:0]          bias;
  logic signed [PW-1:0]          shifted;
  logic                          fits;
  logic signed [COORD_WIDTH-1:0] res_d, res_q;

  assign prod_d = $signed({{COORD_WIDTH{a_i[A_WIDTH-1]}}, a_i})
                * $signed({{A_WIDTH{b_i[COORD_WIDTH-1]}}, b_i});

  // bias negative products so the arithmetic shift rounds toward zero
  assign bias    = $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{prod_q[PW-1]}}});
  assign shifted = (prod_q + bias) >>> FRAC_BITS;
  assign fits    = (shifted[PW-1:COORD_WIDTH-1] == {HW{1'b0}})
                || (shifted[PW-1:COORD_WIDTH-1] == {HW{1'b1}});

  always_comb begin
    if (fits) begin
      res_d = shifted[COORD_WIDTH-1:0];
    end else if (shifted[PW-1]) begin
      res_d = $signed({1'b1, {(COORD_WIDTH-1){1'b0}}});
    end else begin
      res_d = $signed({1'b0, {(COORD_WIDTH-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_prod) begin
      prod_q <= prod_d;
    end
    if (en_i.load_res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- src/rbsi_slab_merge.sv -----
// intersects the three slab intervals, flags disjoint intervals and the hit test
// depends on nothing beyond its ports; one register stage
`default_nettype none

module rbsi_slab_merge #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic signed [COORD_WIDTH-1:0] tnear_i [3],
  input  logic signed [COORD_WIDTH-1:0] tfar_i  [3],
  input  logic        [COORD_WIDTH-2:0] ray_length_i,
  output logic signed [COORD_WIDTH-1:0] tmin_o,
  output logic signed [COORD_WIDTH-1:0] tmax_o,
  output logic                          miss_o,
  output logic                          hit_o
);

  logic signed [COORD_WIDTH-1:0] lo_xy, hi_xy, lo_d, hi_d, lo_q, hi_q;
  logic signed [COORD_WIDTH-1:0] len_s;
  logic                          miss_xy, miss_z, miss_d, hit_d, miss_q, hit_q;

  assign len_s = $signed({1'b0, ray_length_i});

  always_comb begin
    miss_xy = (tnear_i[0] > tfar_i[1]) || (tnear_i[1] > tfar_i[0]);
    lo_xy   = (tnear_i[1] > tnear_i[0]) ? tnear_i[1] : tnear_i[0];
    hi_xy   = (tfar_i[1] < tfar_i[0]) ? tfar_i[1] : tfar_i[0];
    miss_z  = (lo_xy > tfar_i[2]) || (tnear_i[2] > hi_xy);
    lo_d    = (tnear_i[2] > lo_xy) ? tnear_i[2] : lo_xy;
    hi_d    = (tfar_i[2] < hi_xy) ? tfar_i[2] : hi_xy;
    miss_d  = miss_xy || miss_z;
    hit_d   = !miss_d && (lo_d < len_s) && (hi_d > $signed({COORD_WIDTH{1'b0}}));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      miss_q <= miss_d;
      hit_q  <= hit_d;
    end
  end

  assign tmin_o = lo_q;
  assign tmax_o = hi_q;
  assign miss_o = miss_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

// ----- src/ray_box_slab_intersect_unit.sv -----
// top level of the ray/box slab intersection unit: config registers, stage control, datapath
// depends on rbsi_pkg, rbsi_fxmul and rbsi_slab_merge
//
// channel   direction  transaction                          payload
// s_axis    in         one ray                              tdata: origin, recip_dir, dir, ray_length
// m_axis    out        one result                           tdata: entry, exit; tuser: hit
// cfg       in         one box corner register write        cfg_index_i, cfg_data_i
//
// one ray per cycle unless m_axis_tready holds the pipeline; a result is valid once its ray has passed the stages below
// stages: plane distance, slab product, slab t, interval merge, point product,
//   point t*dir, point sum and output register
// reset clears the valid bits and the box corner registers
// each stage holds only while it is full and the stage after it holds, so bubbles close up
`default_nettype none

module ray_box_slab_intersect_unit #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // origin_x, origin_y, origin_z, recip_dir_x/y/z, dir_x/y/z, ray_length, zero fill
  input  logic [((10*COORD_WIDTH-1+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // entry_x, entry_y, entry_z, exit_x, exit_y, exit_z, zero fill
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
  // hit
  output logic                                          m_axis_tuser,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [COORD_WIDTH-1:0]                        cfg_data_i
);

  localparam int unsigned CW          = COORD_WIDTH;
  localparam int unsigned NS          = 7;
  localparam int unsigned OUT_TDATA_W = ((6*COORD_WIDTH+7)/8)*8;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] sum;
    sum = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
    if (sum[CW] != sum[CW-1]) begin
      return sum[CW] ? $signed({1'b1, {(CW-1){1'b0}}}) : $signed({1'b0, {(CW-1){1'b1}}});
    end
    return sum[CW-1:0];
  endfunction

  // box corner registers
  logic signed [CW-1:0] box_min_q [0:2];
  logic signed [CW-1:0] box_max_q [0:2];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rbsi_pkg::rbsi_reg_e'(cfg_index_i))
        rbsi_pkg::REG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        rbsi_pkg::REG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage control
  logic [NS-1:0] valid_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = valid_q[NS-1];

  // input unpacking and plane distances
  logic signed [CW-1:0] org    [0:2];
  logic signed [CW-1:0] rcp    [0:2];
  logic signed [CW-1:0] dir    [0:2];
  logic        [CW-2:0] len_in;
  logic signed [CW-1:0] near_p [0:2];
  logic signed [CW-1:0] far_p  [0:2];
  logic signed [CW:0]   dn_d   [0:2];
  logic signed [CW:0]   df_d   [0:2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      org[a]    = s_axis_tdata[a*CW +: CW];
      rcp[a]    = s_axis_tdata[(3+a)*CW +: CW];
      dir[a]    = s_axis_tdata[(6+a)*CW +: CW];
      near_p[a] = rcp[a][CW-1] ? box_max_q[a] : box_min_q[a];
      far_p[a]  = rcp[a][CW-1] ? box_min_q[a] : box_max_q[a];
      dn_d[a]   = $signed({near_p[a][CW-1], near_p[a]}) - $signed({org[a][CW-1], org[a]});
      df_d[a]   = $signed({far_p[a][CW-1], far_p[a]}) - $signed({org[a][CW-1], org[a]});
    end
    len_in = s_axis_tdata[9*CW +: CW-1];
  end

  // stage registers carried beside the arithmetic units
  logic signed [CW:0]   dn_q     [0:2];
  logic signed [CW:0]   df_q     [0:2];
  logic signed [CW-1:0] rcp_q    [0:2];
  logic signed [CW-1:0] o_q      [0:5][0:2];
  logic signed [CW-1:0] d_q      [0:3][0:2];
  logic        [CW-2:0] len_q    [0:2];
  logic                 miss_q   [4:6];
  logic                 hit_q    [4:5];
  logic                 out_hit_q;
  logic signed [CW-1:0] entry_q  [0:2];
  logic signed [CW-1:0] exit_q   [0:2];

  logic signed [CW-1:0] t_near   [3];
  logic signed [CW-1:0] t_far    [3];
  logic signed [CW-1:0] tmin, tmax;
  logic                 merge_miss, merge_hit;
  logic signed [CW-1:0] td_entry [0:2];
  logic signed [CW-1:0] td_exit  [0:2];

  rbsi_pkg::rbsi_mul_en_t slab_en, pt_en;

  assign slab_en.load_prod = adv[1];
  assign slab_en.load_res  = adv[2];
  assign pt_en.load_prod   = adv[4];
  assign pt_en.load_res    = adv[5];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_fxmul #(
      .A_WIDTH    (CW + 1),
      .COORD_WIDTH(CW),
      .FRAC_BITS  (FRAC_BITS)
    ) u_slab_near (
      .clk_i(clk_i),
      .en_i (slab_en),
      .a_i  (dn_q[a]),
      .b_i  (rcp_q[a]),
      .res_o(t_near[a])
    );

    rbsi_fxmul #(
      .A_WIDTH    (CW + 1),
      .COORD_WIDTH(CW),
      .FRAC_BITS  (FRAC_BITS)
    ) u_slab_far (
      .clk_i(clk_i),
      .en_i (slab_en),
      .a_i  (df_q[a]),
      .b_i  (rcp_q[a]),
      .res_o(t_far[a])
    );

    rbsi_fxmul #(
      .A_WIDTH    (CW),
      .COORD_WIDTH(CW),
      .FRAC_BITS  (FRAC_BITS)
    ) u_pt_entry (
      .clk_i(clk_i),
      .en_i (pt_en),
      .a_i  (tmin),
      .b_i  (d_q[3][a]),
      .res_o(td_entry[a])
    );

    rbsi_fxmul #(
      .A_WIDTH    (CW),
      .COORD_WIDTH(CW),
      .FRAC_BITS  (FRAC_BITS)
    ) u_pt_exit (
      .clk_i(clk_i),
      .en_i (pt_en),
      .a_i  (tmax),
      .b_i  (d_q[3][a]),
      .res_o(td_exit[a])
    );
  end

  rbsi_slab_merge #(
    .COORD_WIDTH(CW)
  ) u_merge (
    .clk_i       (clk_i),
    .load_i      (adv[3]),
    .tnear_i     (t_near),
    .tfar_i      (t_far),
    .ray_length_i(len_q[2]),
    .tmin_o      (tmin),
    .tmax_o      (tmax),
    .miss_o      (merge_miss),
    .hit_o       (merge_hit)
  );

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int a = 0; a < 3; a++) begin
        dn_q[a]    <= dn_d[a];
        df_q[a]    <= df_d[a];
        rcp_q[a]   <= rcp[a];
        o_q[0][a]  <= org[a];
        d_q[0][a]  <= dir[a];
      end
      len_q[0] <= len_in;
    end
    for (int k = 1; k < 6; k++) begin
      if (adv[k]) begin
        o_q[k] <= o_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (adv[k]) begin
        d_q[k] <= d_q[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (adv[k]) begin
        len_q[k] <= len_q[k-1];
      end
    end
    if (adv[4]) begin
      miss_q[4] <= merge_miss;
      hit_q[4]  <= merge_hit;
    end
    if (adv[5]) begin
      miss_q[5] <= miss_q[4];
      hit_q[5]  <= hit_q[4];
    end
    if (adv[6]) begin
      miss_q[6] <= miss_q[5];
      out_hit_q <= hit_q[5];
      for (int a = 0; a < 3; a++) begin
        entry_q[a] <= miss_q[5] ? '0 : sat_add(o_q[5][a], td_entry[a]);
        exit_q[a]  <= miss_q[5] ? '0 : sat_add(o_q[5][a], td_exit[a]);
      end
    end
  end

  assign m_axis_tuser = out_hit_q;
  assign m_axis_tdata = OUT_TDATA_W'({exit_q[2], exit_q[1], exit_q[0],
                                      entry_q[2], entry_q[1], entry_q[0]});

  // a full stall must come only from a pipeline with every stage occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_q))
    else $error("input stalled while a stage is empty");

  // early miss results carry no points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && miss_q[6]) |-> (m_axis_tdata == '0))
    else $error("miss result with nonzero points");

  // a hit never comes from disjoint intervals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> !miss_q[6])
    else $error("hit flagged on an early miss");

endmodule

`default_nettype wire

// ----- bench/ray_box_slab_intersect_checker.sv -----
// result checker for the ray/box slab intersection unit: tracks the box corner writes,
// predicts one intersection result per accepted ray and compares the output stream in order
// depends on rbsi_pkg for the register indexes
`timescale 1ns / 100ps

module ray_box_slab_intersect_checker #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            ray_valid_i,
  input  logic                            ray_ready_i,
  // origin_x, origin_y, origin_z, recip_dir_x/y/z, dir_x/y/z, ray_length, zero fill
  input  logic [((10*CW-1+7)/8)*8-1:0]    ray_data_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  // entry_x, entry_y, entry_z, exit_x, exit_y, exit_z, zero fill
  input  logic [((6*CW+7)/8)*8-1:0]       res_data_i,
  // hit
  input  logic                            res_hit_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CW-1:0]                   cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int unsigned IN_W = ((10*CW-1+7)/8)*8;
  localparam longint SAT_HI = (longint'(1) <<< (CW-1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic                 hit;
    logic [2:0][CW-1:0]   entry_pt;
    logic [2:0][CW-1:0]   exit_pt;
  } slab_hit_t;

  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];
  slab_hit_t            predicted_hits [$];

  function automatic logic signed [63:0] sext_coord(input logic [CW-1:0] v);
    return {{(64-CW){v[CW-1]}}, v};
  endfunction

  // exact product, magnitude truncated by FB bits, saturated to the coordinate range
  function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic         neg;
    logic [127:0] mag_a;
    logic [127:0] mag_b;
    logic [127:0] q;
    logic [127:0] lim;
    neg   = (a < 0) != (b < 0);
    mag_a = (a < 0) ? {64'd0, -a} : {64'd0, a};
    mag_b = (b < 0) ? {64'd0, -b} : {64'd0, b};
    q     = (mag_a * mag_b) >> FB;
    lim   = neg ? 128'(SAT_HI) + 128'd1 : 128'(SAT_HI);
    if (q > lim) q = lim;
    if (neg) return -$signed(q[63:0]);
    return $signed(q[63:0]);
  endfunction

  function automatic logic [CW-1:0] sat_coord(input logic signed [63:0] v);
    if (v > SAT_HI) return SAT_HI[CW-1:0];
    if (v < SAT_LO) return SAT_LO[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic slab_hit_t predict_intersection(input logic [IN_W-1:0] d);
    logic signed [63:0] org [3];
    logic signed [63:0] rcp [3];
    logic signed [63:0] dv  [3];
    logic signed [63:0] len;
    logic signed [63:0] t_lo;
    logic signed [63:0] t_hi;
    logic signed [63:0] tn;
    logic signed [63:0] tf;
    logic signed [63:0] near_p;
    logic signed [63:0] far_p;
    slab_hit_t          r;
    for (int i = 0; i < 3; i++) begin
      org[i] = sext_coord(d[i*CW +: CW]);
      rcp[i] = sext_coord(d[(3+i)*CW +: CW]);
      dv[i]  = sext_coord(d[(6+i)*CW +: CW]);
    end
    len  = {{(65-CW){1'b0}}, d[9*CW +: CW-1]};
    r    = '0;
    t_lo = 0;
    t_hi = 0;
    for (int a = 0; a < 3; a++) begin
      near_p = (rcp[a] < 0) ? 64'(box_hi[a]) : 64'(box_lo[a]);
      far_p  = (rcp[a] < 0) ? 64'(box_lo[a]) : 64'(box_hi[a]);
      tn     = fx_product(near_p - org[a], rcp[a]);
      tf     = fx_product(far_p - org[a], rcp[a]);
      if (a == 0) begin
        t_lo = tn;
        t_hi = tf;
      end else begin
        // disjoint slabs: early miss, all points zero
        if (t_lo > tf || tn > t_hi) return r;
        if (tn > t_lo) t_lo = tn;
        if (tf < t_hi) t_hi = tf;
      end
    end
    r.hit = (t_lo < len) && (t_hi > 0);
    for (int i = 0; i < 3; i++) begin
      r.entry_pt[i] = sat_coord(org[i] + fx_product(t_lo, dv[i]));
      r.exit_pt[i]  = sat_coord(org[i] + fx_product(t_hi, dv[i]));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CW-1:0] want,
                             input logic [CW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slab_hit_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
      end
      predicted_hits.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rbsi_pkg::REG_BOX_MIN_X: box_lo[0] = cfg_data_i;
          rbsi_pkg::REG_BOX_MIN_Y: box_lo[1] = cfg_data_i;
          rbsi_pkg::REG_BOX_MIN_Z: box_lo[2] = cfg_data_i;
          rbsi_pkg::REG_BOX_MAX_X: box_hi[0] = cfg_data_i;
          rbsi_pkg::REG_BOX_MAX_Y: box_hi[1] = cfg_data_i;
          rbsi_pkg::REG_BOX_MAX_Z: box_hi[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (predicted_hits.size() == 0) begin
          $error("result transaction with no ray outstanding");
          fail_count_o++;
        end else begin
          want = predicted_hits.pop_front();
          check_field("hit", CW'(want.hit), CW'(res_hit_i));
          check_field("entry_x", want.entry_pt[0], res_data_i[0*CW +: CW]);
          check_field("entry_y", want.entry_pt[1], res_data_i[1*CW +: CW]);
          check_field("entry_z", want.entry_pt[2], res_data_i[2*CW +: CW]);
          check_field("exit_x", want.exit_pt[0], res_data_i[3*CW +: CW]);
          check_field("exit_y", want.exit_pt[1], res_data_i[4*CW +: CW]);
          check_field("exit_z", want.exit_pt[2], res_data_i[5*CW +: CW]);
        end
      end
      if (ray_valid_i && ray_ready_i)
        predicted_hits.insert(predicted_hits.size(), predict_intersection(ray_data_i));
      pending_o = predicted_hits.size();
    end
  end

endmodule

// ----- bench/ray_box_slab_intersect_unit_tb.sv -----
// stimulus top for the ray/box slab intersection unit: directed and random rays over
// several box settings, random idling on both stream sides, verdict from the checker
// depends on rbsi_pkg, ray_box_slab_intersect_unit and ray_box_slab_intersect_checker
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_tb;

  localparam int unsigned CW    = 32;
  localparam int unsigned IN_W  = ((10*CW-1+7)/8)*8;
  localparam int unsigned OUT_W = ((6*CW+7)/8)*8;
  localparam int ONE            = 65536;
  localparam logic [31:0] SAT_P = 32'h7fffffff;
  localparam logic [31:0] SAT_N = 32'h80000000;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASES         = 8;
  localparam int RAYS_PER_PHASE = 150;

  typedef enum logic [1:0] {
    BOX_EXTREME,
    BOX_SWAPPED,
    BOX_RAW,
    BOX_RANDOM
  } box_mode_e;

  logic                                 clk_i;
  logic                                 rst_ni        = 1'b0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [IN_W-1:0]                      s_axis_tdata  = '0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]                     m_axis_tdata;
  logic                                 m_axis_tuser;
  logic                                 cfg_valid     = 1'b0;
  logic                                 cfg_ready;
  logic [rbsi_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
  logic [CW-1:0]                        cfg_data      = '0;

  int     fail_count;
  int     pending;
  int     cycle_count;
  int     rays_sent   = 0;
  int     box_count   = 0;
  bit     no_idle     = 1'b0;
  longint box_center [3];
  longint box_half   [3];

  ray_box_slab_intersect_unit #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (16)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  ray_box_slab_intersect_checker #(
    .CW(CW),
    .FB(16)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ray_valid_i (s_axis_tvalid),
    .ray_ready_i (s_axis_tready),
    .ray_data_i  (s_axis_tdata),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_hit_i   (m_axis_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side back pressure
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 9);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run stopped at the cycle limit with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [31:0] rx, input logic [31:0] ry, input logic [31:0] rz,
                          input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
                          input logic [31:0] len);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, len[30:0], dz, dy, dx, rz, ry, rx, oz, oy, ox};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rays_sent++;
  endtask

  // wait until every ray in flight has produced its result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input rbsi_pkg::rbsi_reg_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic write_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                           input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
    drain();
    write_reg(rbsi_pkg::REG_BOX_MIN_X, lx);
    write_reg(rbsi_pkg::REG_BOX_MIN_Y, ly);
    write_reg(rbsi_pkg::REG_BOX_MIN_Z, lz);
    write_reg(rbsi_pkg::REG_BOX_MAX_X, hx);
    write_reg(rbsi_pkg::REG_BOX_MAX_Y, hy);
    write_reg(rbsi_pkg::REG_BOX_MAX_Z, hz);
    cfg_valid <= 1'b0;
    box_count++;
  endtask

  function automatic longint rand_span(input int r);
    return longint'($urandom_range(0, 2*r)) - r;
  endfunction

  // extreme corners, swapped corners, raw random words or a random box
  task automatic set_phase_box(input box_mode_e mode);
    logic [31:0] lo [3];
    logic [31:0] hi [3];
    for (int a = 0; a < 3; a++) begin
      box_center[a] = rand_span(8*ONE);
      box_half[a]   = $urandom_range(0, 4*ONE);
      lo[a] = 32'(box_center[a] - box_half[a]);
      hi[a] = 32'(box_center[a] + box_half[a]);
      case (mode)
        BOX_EXTREME: begin
          lo[a] = SAT_N;
          hi[a] = SAT_P;
          box_center[a] = 0;
          box_half[a]   = 16*ONE;
        end
        BOX_SWAPPED: begin
          lo[a] = 32'(box_center[a] + box_half[a]);
          hi[a] = 32'(box_center[a] - box_half[a]);
        end
        BOX_RAW: begin
          lo[a] = $urandom;
          hi[a] = $urandom;
          box_center[a] = (longint'($signed(lo[a])) + longint'($signed(hi[a]))) / 2;
          box_half[a]   = 4*ONE;
        end
        default: ;
      endcase
    end
    write_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  task automatic send_random_ray();
    logic [31:0] org [3];
    logic [31:0] rcp [3];
    logic [31:0] dir [3];
    logic [30:0] len;
    longint      o;
    longint      delta;
    longint      dv;
    longint      q;
    int          shift;
    if ($urandom_range(0, 99) < 20) begin
      for (int a = 0; a < 3; a++) begin
        org[a] = $urandom;
        rcp[a] = $urandom;
        dir[a] = $urandom;
      end
      len = 31'($urandom);
    end else begin
      shift = $urandom_range(0, 4);
      for (int a = 0; a < 3; a++) begin
        o     = box_center[a] + rand_span(16*ONE);
        delta = box_center[a] + rand_span(int'(box_half[a]) + ONE) - o;
        dv    = ($urandom_range(0, 9) == 0) ? 0 : (delta >>> shift);
        if (dv == 0) begin
          rcp[a] = $urandom_range(0, 1) ? SAT_P : SAT_N;
        end else begin
          q = (longint'(1) <<< 32) / dv;
          if (q > longint'(32'h7fffffff)) q = longint'(32'h7fffffff);
          if (q < -longint'(32'h80000000)) q = -longint'(32'h80000000);
          rcp[a] = 32'(q);
        end
        org[a] = 32'(o);
        dir[a] = 32'(dv);
      end
      len = ($urandom_range(0, 9) < 7) ? 31'($urandom_range(0, 32*ONE)) : 31'($urandom);
    end
    send_ray(org[0], org[1], org[2], rcp[0], rcp[1], rcp[2], dir[0], dir[1], dir[2],
             {1'b0, len});
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // box still at its reset value
    send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_ray(SAT_P, SAT_P, SAT_P, SAT_N, SAT_N, SAT_N, SAT_N, SAT_N, SAT_N, 32'h7fffffff);

    // unit cube around the origin
    write_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray(-3*ONE, 0, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, 10*ONE);
    send_ray(3*ONE, 0, 0, -ONE, SAT_P, SAT_P, -ONE, 0, 0, 10*ONE);
    // disjoint slabs on y, then on z
    send_ray(-3*ONE, 5*ONE, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, 10*ONE);
    send_ray(-3*ONE, 0, 5*ONE, ONE, SAT_P, SAT_P, ONE, 0, 0, 10*ONE);
    // overlap beyond the length, near t equal to the length
    send_ray(-3*ONE, 0, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, ONE);
    send_ray(-3*ONE, 0, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, 2*ONE);
    // far t exactly zero, box behind the ray
    send_ray(ONE, 0, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, 10*ONE);
    send_ray(3*ONE, 0, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, 10*ONE);
    // slabs that only touch
    send_ray(-3*ONE, -5*ONE, 0, ONE, ONE, SAT_P, ONE, ONE, 0, 10*ONE);
    // zero reciprocal
    send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 10*ONE);
    send_ray(5*ONE, 0, 0, 0, SAT_N, SAT_P, 0, 0, 0, 10*ONE);
    // point sums that saturate both ways
    send_ray(-3*ONE, 0, 0, ONE, SAT_P, SAT_P, SAT_P, SAT_P, SAT_P, 10*ONE);
    send_ray(-3*ONE, 0, 0, ONE, SAT_P, SAT_P, SAT_N, SAT_N, SAT_N, 32'h7fffffff);
    send_ray(0, 0, 0, SAT_N, SAT_N, SAT_N, -ONE, -ONE, -ONE, 32'h7fffffff);

    // widest box
    write_box(SAT_N, SAT_N, SAT_N, SAT_P, SAT_P, SAT_P);
    send_ray(SAT_N, SAT_N, SAT_N, SAT_P, SAT_P, SAT_P, SAT_P, SAT_P, SAT_P, 32'h7fffffff);
    send_ray(SAT_P, SAT_P, SAT_P, SAT_N, SAT_N, SAT_N, SAT_N, 0, SAT_P, 0);

    // minimum corner above the maximum corner
    write_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_ray(-3*ONE, 0, 0, ONE, SAT_P, SAT_P, ONE, 0, 0, 10*ONE);
    send_ray(0, 0, 0, -ONE, ONE, -ONE, -ONE, ONE, -ONE, 10*ONE);

    for (int phase = 0; phase < PHASES; phase++) begin
      set_phase_box(phase < 3 ? box_mode_e'(phase) : BOX_RANDOM);
      no_idle = (phase == 5);
      repeat (RAYS_PER_PHASE) send_random_ray();
    end
    no_idle = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);

    $display("%0d rays checked against %0d box settings, directed edge cases first,", rays_sent,
             box_count + 1);
    $display("then aimed and raw random rays with random gaps and back pressure");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
